>>> rtl/kci_pkg.sv
// shared types and constants for the keyframe curve interpolator
// no dependencies
`default_nettype none
package kci_pkg;

  localparam int FRAC_BITS = 16;
  localparam int T_BITS    = 16;
  localparam int VAL_W     = 32;
  localparam int TW        = T_BITS + 1;    // t spans 0..one inclusive
  localparam int REM_W     = VAL_W + 1;
  localparam int WW        = T_BITS + 4;    // signed blend weight
  localparam int PW        = VAL_W + WW;    // one weighted term
  localparam int SW        = PW + 2;        // sum of four terms
  localparam int RW        = SW - T_BITS;   // sum after the fraction shift

  typedef enum logic [1:0] {
    FN_HOLD    = 2'd0,
    FN_LINEAR  = 2'd1,
    FN_HERMITE = 2'd2,
    FN_BEZIER  = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    TS_ZERO = 2'd0,
    TS_ONE  = 2'd1,
    TS_DIV  = 2'd2
  } tsel_t;

  typedef struct packed {
    func_e_t                   func;
    logic                      hold;
    logic                      whole;
    tsel_t                     tsel;
    logic signed [VAL_W-1:0]   lv;
    logic signed [VAL_W-1:0]   ot;
    logic signed [VAL_W-1:0]   it;
    logic signed [VAL_W-1:0]   rv;
  } side_t;

endpackage
`default_nettype wire

>>> rtl/kci_div.sv
// pipelined restoring divider, one quotient bit per stage, side data rides along
// depends on kci_pkg
`default_nettype none
module kci_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic [kci_pkg::VAL_W-1:0]   num,
  input  wire logic [kci_pkg::VAL_W-1:0]   den,
  input  wire kci_pkg::side_t              in_side,
  output logic                             out_vld,
  output logic [kci_pkg::T_BITS-1:0]       quot,
  output kci_pkg::side_t                   out_side
);
  import kci_pkg::*;

  logic [T_BITS-1:0]  vld_r;
  logic [VAL_W-1:0]   rem_r  [T_BITS];
  logic [VAL_W-1:0]   den_r  [T_BITS];
  logic [T_BITS-1:0]  q_r    [T_BITS];
  side_t              side_r [T_BITS];

  for (genvar i = 0; i < T_BITS; i++) begin : g_stage
    logic [VAL_W-1:0]  rem_in;
    logic [VAL_W-1:0]  den_in;
    logic [T_BITS-1:0] q_in;
    side_t             side_in;
    logic              v_in;
    logic [REM_W-1:0]  sh;
    logic [REM_W-1:0]  diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign q_in    = '0;
      assign side_in = in_side;
      assign v_in    = in_vld;
    end else begin : g_rest
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign q_in    = q_r[i-1];
      assign side_in = side_r[i-1];
      assign v_in    = vld_r[i-1];
    end

    // remainder stays below the divisor, so the shifted value fits REM_W
    assign sh   = {rem_in, 1'b0};
    assign diff = sh - {1'b0, den_in};
    assign ge   = ~diff[REM_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? diff[VAL_W-1:0] : sh[VAL_W-1:0];
      den_r[i]  <= den_in;
      q_r[i]    <= {q_in[T_BITS-2:0], ge};
      side_r[i] <= side_in;
    end
  end

  assign out_vld  = vld_r[T_BITS-1];
  assign quot     = q_r[T_BITS-1];
  assign out_side = side_r[T_BITS-1];

endmodule
`default_nettype wire

>>> rtl/keyframe_curve_interpolator.sv
// top level of the keyframe curve interpolator: fraction, weights, blend, clamp
// depends on kci_pkg and kci_div
`default_nettype none
// One request per clock: busy never rises, so a request is taken at every edge
// with start high. Each request gives exactly one result, marked by out_valid
// for one cycle; the receiver cannot stall. A request passes through the input
// register and the fraction divider, which resolves one quotient bit per stage,
// followed by two weight multiply stages, a weight forming stage, a multiply
// stage, an adder stage and the output register. Hold mode and equal keyframe
// times pass the left value through, truncated when whole-number mode is set.
module keyframe_curve_interpolator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_func,
  input  wire logic [31:0]                       in_now_time,
  input  wire logic [31:0]                       in_left_time,
  input  wire logic [31:0]                       in_right_time,
  input  wire logic signed [31:0]                in_left_value,
  input  wire logic signed [31:0]                in_left_out_tan,
  input  wire logic signed [31:0]                in_right_in_tan,
  input  wire logic signed [31:0]                in_right_value,
  input  wire logic                              in_whole_number,
  output logic                                   out_valid,
  output logic signed [31:0]                     out_value,
  output logic                                   out_saturated
);
  import kci_pkg::*;

  localparam logic [TW-1:0] ONE_T  = TW'(1) << T_BITS;
  localparam logic [VAL_W-1:0] FRAC_MASK = (VAL_W'(1) << FRAC_BITS) - VAL_W'(1);
  localparam logic [VAL_W-1:0] FRAC_ONE  = VAL_W'(1) << FRAC_BITS;
  localparam int LAT_AFTER_A = 1;

  // fully pipelined, so requests are never refused
  assign busy = 1'b0;

  // ---------------- stage 0: capture request, classify, form divider operands
  logic              v0_r;
  side_t             side0_r;
  logic [VAL_W-1:0]  num0_r;
  logic [VAL_W-1:0]  den0_r;

  side_t side0_nxt;
  always_comb begin
    side0_nxt.func  = func_e_t'(in_func);
    side0_nxt.hold  = (in_left_time == in_right_time) || (func_e_t'(in_func) == FN_HOLD);
    side0_nxt.whole = in_whole_number;
    side0_nxt.lv    = in_left_value;
    side0_nxt.ot    = in_left_out_tan;
    side0_nxt.it    = in_right_in_tan;
    side0_nxt.rv    = in_right_value;
    // order matters: before the left key wins over past the right key
    priority if (in_now_time <= in_left_time) begin
      side0_nxt.tsel = TS_ZERO;
    end else if (in_now_time >= in_right_time) begin
      side0_nxt.tsel = TS_ONE;
    end else begin
      side0_nxt.tsel = TS_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    side0_r <= side0_nxt;
    num0_r  <= in_now_time - in_left_time;
    den0_r  <= in_right_time - in_left_time;
  end

  // ---------------- divider: t = (now - left) * 2^T / (right - left)
  logic              vd;
  logic [T_BITS-1:0] qd;
  side_t             sided;

  // numerator is below the denominator whenever the quotient is used
  kci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v0_r),
    .num      (num0_r),
    .den      (den0_r),
    .in_side  (side0_r),
    .out_vld  (vd),
    .quot     (qd),
    .out_side (sided)
  );

  // ---------------- stage 1: pick t, form u, square both
  logic              v1_r;
  side_t             side1_r;
  logic [TW-1:0]     t1_r, u1_r;
  logic [2*TW-1:0]   tt1_r, uu1_r;

  logic [TW-1:0] t_sel;
  always_comb begin
    unique case (sided.tsel)
      TS_ZERO: t_sel = '0;
      TS_ONE:  t_sel = ONE_T;
      TS_DIV:  t_sel = {1'b0, qd};
      default: t_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= sided;
    t1_r    <= t_sel;
    u1_r    <= ONE_T - t_sel;
    tt1_r   <= t_sel * t_sel;
    uu1_r   <= (ONE_T - t_sel) * (ONE_T - t_sel);
  end

  // ---------------- stage 2: cube terms from truncated squares
  logic              v2_r;
  side_t             side2_r;
  logic [TW-1:0]     t2_r, u2_r, tt2_r;
  logic [2*TW-1:0]   ttt2_r, uuu2_r, tuu2_r, ttu2_r;

  logic [TW-1:0] tt1, uu1;
  assign tt1 = tt1_r[T_BITS +: TW];
  assign uu1 = uu1_r[T_BITS +: TW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    side2_r <= side1_r;
    t2_r    <= t1_r;
    u2_r    <= u1_r;
    tt2_r   <= tt1;
    ttt2_r  <= tt1 * t1_r;
    uuu2_r  <= uu1 * u1_r;
    tuu2_r  <= t1_r * uu1;
    ttu2_r  <= tt1 * u1_r;
  end

  // ---------------- stage 3: signed blend weights per mode
  logic              v3_r;
  side_t             side3_r;
  logic signed [WW-1:0] w0_r, w1_r, w2_r, w3_r;

  logic signed [WW-1:0] ts, us, tts, ttts, uuus, tuus, ttus, ones;
  logic signed [WW-1:0] w0_nxt, w1_nxt, w2_nxt, w3_nxt;
  always_comb begin
    ts   = WW'(t2_r);
    us   = WW'(u2_r);
    tts  = WW'(tt2_r);
    ttts = WW'(ttt2_r[T_BITS +: TW]);
    uuus = WW'(uuu2_r[T_BITS +: TW]);
    tuus = WW'(tuu2_r[T_BITS +: TW]);
    ttus = WW'(ttu2_r[T_BITS +: TW]);
    ones = WW'(ONE_T);
    unique case (side2_r.func)
      FN_LINEAR: begin
        w0_nxt = us;
        w1_nxt = '0;
        w2_nxt = '0;
        w3_nxt = ts;
      end
      FN_HERMITE: begin
        w0_nxt = (ttts <<< 1) - (tts + (tts <<< 1)) + ones;
        w1_nxt = ttts - (tts <<< 1) + ts;
        w2_nxt = ttts - tts;
        w3_nxt = (tts + (tts <<< 1)) - (ttts <<< 1);
      end
      FN_BEZIER: begin
        w0_nxt = uuus;
        w1_nxt = tuus + (tuus <<< 1);
        w2_nxt = ttus + (ttus <<< 1);
        w3_nxt = ttts;
      end
      default: begin
        // hold mode: result is taken from the left value later
        w0_nxt = '0;
        w1_nxt = '0;
        w2_nxt = '0;
        w3_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    side3_r <= side2_r;
    w0_r    <= w0_nxt;
    w1_r    <= w1_nxt;
    w2_r    <= w2_nxt;
    w3_r    <= w3_nxt;
  end

  // ---------------- stage 4: four value by weight products
  logic              v4_r;
  side_t             side4_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    side4_r <= side3_r;
    p0_r    <= PW'(side3_r.lv) * PW'(w0_r);
    p1_r    <= PW'(side3_r.ot) * PW'(w1_r);
    p2_r    <= PW'(side3_r.it) * PW'(w2_r);
    p3_r    <= PW'(side3_r.rv) * PW'(w3_r);
  end

  // ---------------- stage 5: exact sum
  logic              v5_r;
  side_t             side5_r;
  logic signed [SW-1:0] sum5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    side5_r <= side4_r;
    sum5_r  <= (SW'(p0_r) + SW'(p1_r)) + (SW'(p2_r) + SW'(p3_r));
  end

  // ---------------- stage 6: floor shift, clamp, hold, whole-number truncation
  logic              v6_r;
  logic [VAL_W-1:0]  val6_r;
  logic              sat6_r;

  logic [RW-1:0]    shifted;   // dropping the low bits is a floor shift
  logic             fits;
  logic [VAL_W-1:0] clamped;
  logic             sat_nxt;
  logic [VAL_W-1:0] pre;
  logic [VAL_W-1:0] val_nxt;
  always_comb begin
    shifted = sum5_r[SW-1:T_BITS];
    fits    = (&shifted[RW-1:VAL_W-1]) || !(|shifted[RW-1:VAL_W-1]);
    if (fits) begin
      clamped = shifted[VAL_W-1:0];
    end else if (shifted[RW-1]) begin
      clamped = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      clamped = {1'b0, {(VAL_W-1){1'b1}}};
    end
    sat_nxt = !side5_r.hold && !fits;
    pre     = side5_r.hold ? side5_r.lv : clamped;
    // truncate toward zero: negatives with a fraction move up one whole step
    if (side5_r.whole) begin
      val_nxt = (pre & ~FRAC_MASK)
              + ((pre[VAL_W-1] && (|(pre & FRAC_MASK))) ? FRAC_ONE : '0);
    end else begin
      val_nxt = pre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    val6_r <= val_nxt;
    sat6_r <= sat_nxt;
  end

  assign out_valid     = v6_r;
  assign out_value     = val6_r;
  assign out_saturated = v6_r && sat6_r;

  // ---------------- checks
  a_sat_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_saturated |-> out_valid)
    else $error("saturation flag without a result");

  a_sum_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> ##LAT_AFTER_A out_valid)
    else $error("summed request did not reach the output");

  a_hold_never_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && side5_r.hold) |=> !out_saturated)
    else $error("held value flagged as saturated");

  a_sat_value_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_saturated && !$past(side5_r.whole)) |->
      (out_value == 32'sh7FFF_FFFF || out_value == 32'sh8000_0000))
    else $error("saturated result not at a rail");

endmodule
`default_nettype wire
